>>> rtl/yrcc_pkg.sv
// types and coefficient constants for the ycbcr/rgb color converter
// no dependencies; used by yuv_rgb_color_convert_unit

package yrcc_pkg;

    typedef logic signed [11:0] coef_t;

    // chroma terms for ycbcr to rgb, products are shifted right by 10
    typedef struct packed {
        coef_t rv;
        coef_t gu;
        coef_t gv;
        coef_t bu;
    } yuv_coef_t;

    // rows of the rgb to ycbcr matrix, sums are divided by 1024
    typedef struct packed {
        coef_t y_r;
        coef_t y_g;
        coef_t y_b;
        coef_t u_r;
        coef_t u_g;
        coef_t u_b;
        coef_t v_r;
        coef_t v_g;
        coef_t v_b;
    } rgb_coef_t;

    localparam logic STD_BT601 = 1'b0;
    localparam logic STD_BT709 = 1'b1;

    localparam logic ACT_YUV_TO_RGB = 1'b0;
    localparam logic ACT_RGB_TO_YUV = 1'b1;

    localparam yuv_coef_t YUV_COEF_601 = '{
        rv: 12'sd1437, gu: -12'sd352, gv: -12'sd731, bu: 12'sd1812
    };
    localparam yuv_coef_t YUV_COEF_709 = '{
        rv: 12'sd1608, gu: -12'sd191, gv: -12'sd478, bu: 12'sd1900
    };

    localparam rgb_coef_t RGB_COEF_601 = '{
        y_r: 12'sd306,  y_g: 12'sd601,  y_b: 12'sd116,
        u_r: -12'sd172, u_g: -12'sd337, u_b: 12'sd509,
        v_r: 12'sd509,  v_g: -12'sd427, v_b: -12'sd82
    };
    localparam rgb_coef_t RGB_COEF_709 = '{
        y_r: 12'sd217,  y_g: 12'sd732,  y_b: 12'sd73,
        u_r: -12'sd117, u_g: -12'sd394, u_b: 12'sd512,
        v_r: 12'sd512,  v_g: -12'sd465, v_b: -12'sd46
    };

endpackage

>>> rtl/yuv_rgb_color_convert_unit.sv
// top level of the ycbcr/rgb color converter, one pixel per transfer
// depends on yrcc_pkg for coefficient sets and codes

// Converts one pixel per transfer, either ycbcr (signed chroma) to rgb or rgb to
// ycbcr with a uyvy word, using the bt.601 or bt.709 coefficients chosen by the
// standard_select register (written over the cfg port; the user must write it only
// while no pixel is in flight, as the block itself does not enforce this). The block
// takes one pixel every clock cycle while the output is not stalled; each pixel passes
// through the constant multipliers in the first stage, the adders in the second, and
// the divide by 1024, clamp and output register in the third. Backpressure on the
// output stalls the pipeline without losing or repeating pixels, and bubbles are filled as they appear.

module yuv_rgb_color_convert_unit (
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,

    input  logic              in_valid,
    output logic              in_ready,
    input  logic              action,
    input  logic [7:0]        luma_in,
    input  logic signed [7:0] cb_in,
    input  logic signed [7:0] cr_in,
    input  logic [7:0]        red_in,
    input  logic [7:0]        green_in,
    input  logic [7:0]        blue_in,

    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        red_out,
    output logic [7:0]        green_out,
    output logic [7:0]        blue_out,
    output logic [7:0]        luma_out,
    output logic signed [7:0] cb_out,
    output logic signed [7:0] cr_out,
    output logic [31:0]       packed_uyvy
);

    function automatic logic [7:0] clamp_u8_rgb(input logic signed [10:0] s);
        logic [7:0] r;
        if (s < 11'sd0)
            r = 8'd0;
        else if (s > 11'sd255)
            r = 8'd255;
        else
            r = s[7:0];
        return r;
    endfunction

    function automatic logic signed [22:0] div1024_trunc(input logic signed [22:0] s);
        logic signed [22:0] adj;
        adj = s + (s[22] ? 23'sd1023 : 23'sd0);
        return adj >>> 10;
    endfunction

    // configuration register
    logic standard_select_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            standard_select_reg <= yrcc_pkg::STD_BT601;
        else if (cfg_valid && cfg_ready)
            standard_select_reg <= cfg_data;
    end

    // stage enables
    logic valid1_reg, valid2_reg, valid3_reg;
    logic en1, en2, en3;

    assign en3      = !valid3_reg || out_ready;
    assign en2      = !valid2_reg || en3;
    assign en1      = !valid1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                valid1_reg <= in_valid;
            if (en2)
                valid2_reg <= valid1_reg;
            if (en3)
                valid3_reg <= valid2_reg;
        end
    end

    // stage 1: constant products
    yrcc_pkg::yuv_coef_t yc;
    yrcc_pkg::rgb_coef_t rc;

    logic signed [19:0] p_rv_next, p_gu_next, p_gv_next, p_bu_next;
    logic signed [20:0] p_yr_next, p_yg_next, p_yb_next;
    logic signed [20:0] p_ur_next, p_ug_next, p_ub_next;
    logic signed [20:0] p_vr_next, p_vg_next, p_vb_next;
    logic signed [20:0] r_ext, g_ext, b_ext;

    always_comb
    begin
        yc = (standard_select_reg == yrcc_pkg::STD_BT709) ?
             yrcc_pkg::YUV_COEF_709 : yrcc_pkg::YUV_COEF_601;
        rc = (standard_select_reg == yrcc_pkg::STD_BT709) ?
             yrcc_pkg::RGB_COEF_709 : yrcc_pkg::RGB_COEF_601;

        p_rv_next = 20'(yc.rv) * 20'(cr_in);
        p_gu_next = 20'(yc.gu) * 20'(cb_in);
        p_gv_next = 20'(yc.gv) * 20'(cr_in);
        p_bu_next = 20'(yc.bu) * 20'(cb_in);

        r_ext = 21'($signed({1'b0, red_in}));
        g_ext = 21'($signed({1'b0, green_in}));
        b_ext = 21'($signed({1'b0, blue_in}));

        p_yr_next = 21'(rc.y_r) * r_ext;
        p_yg_next = 21'(rc.y_g) * g_ext;
        p_yb_next = 21'(rc.y_b) * b_ext;
        p_ur_next = 21'(rc.u_r) * r_ext;
        p_ug_next = 21'(rc.u_g) * g_ext;
        p_ub_next = 21'(rc.u_b) * b_ext;
        p_vr_next = 21'(rc.v_r) * r_ext;
        p_vg_next = 21'(rc.v_g) * g_ext;
        p_vb_next = 21'(rc.v_b) * b_ext;
    end

    logic               act1_reg;
    logic [7:0]         luma1_reg;
    logic signed [19:0] p_rv_reg, p_gu_reg, p_gv_reg, p_bu_reg;
    logic signed [20:0] p_yr_reg, p_yg_reg, p_yb_reg;
    logic signed [20:0] p_ur_reg, p_ug_reg, p_ub_reg;
    logic signed [20:0] p_vr_reg, p_vg_reg, p_vb_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            act1_reg  <= action;
            luma1_reg <= luma_in;
            p_rv_reg  <= p_rv_next;
            p_gu_reg  <= p_gu_next;
            p_gv_reg  <= p_gv_next;
            p_bu_reg  <= p_bu_next;
            p_yr_reg  <= p_yr_next;
            p_yg_reg  <= p_yg_next;
            p_yb_reg  <= p_yb_next;
            p_ur_reg  <= p_ur_next;
            p_ug_reg  <= p_ug_next;
            p_ub_reg  <= p_ub_next;
            p_vr_reg  <= p_vr_next;
            p_vg_reg  <= p_vg_next;
            p_vb_reg  <= p_vb_next;
        end
    end

    // stage 2: shifted chroma terms added to luma, matrix rows summed
    logic signed [19:0] rv_sh, gu_sh, gv_sh, bu_sh;
    logic signed [10:0] luma_ext;
    logic signed [10:0] sum_r_next, sum_g_next, sum_b_next;
    logic signed [22:0] sum_y_next, sum_u_next, sum_v_next;

    always_comb
    begin
        rv_sh    = p_rv_reg >>> 10;
        gu_sh    = p_gu_reg >>> 10;
        gv_sh    = p_gv_reg >>> 10;
        bu_sh    = p_bu_reg >>> 10;
        luma_ext = 11'($signed({3'b000, luma1_reg}));

        sum_r_next = luma_ext + 11'(rv_sh);
        sum_g_next = luma_ext + 11'(gu_sh) + 11'(gv_sh);
        sum_b_next = luma_ext + 11'(bu_sh);

        sum_y_next = 23'(p_yr_reg) + 23'(p_yg_reg) + 23'(p_yb_reg);
        sum_u_next = 23'(p_ur_reg) + 23'(p_ug_reg) + 23'(p_ub_reg);
        sum_v_next = 23'(p_vr_reg) + 23'(p_vg_reg) + 23'(p_vb_reg);
    end

    logic               act2_reg;
    logic signed [10:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic signed [22:0] sum_y_reg, sum_u_reg, sum_v_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            act2_reg  <= act1_reg;
            sum_r_reg <= sum_r_next;
            sum_g_reg <= sum_g_next;
            sum_b_reg <= sum_b_next;
            sum_y_reg <= sum_y_next;
            sum_u_reg <= sum_u_next;
            sum_v_reg <= sum_v_next;
        end
    end

    // stage 3: divide, clamp, zero the unused direction, pack
    logic signed [22:0] q_y, q_u, q_v;
    logic [7:0]         y8, u8, v8;
    logic [7:0]         red_next, green_next, blue_next;
    logic [7:0]         luma_next, cb_next, cr_next;
    logic [31:0]        packed_next;

    always_comb
    begin
        q_y = div1024_trunc(sum_y_reg);
        q_u = div1024_trunc(sum_u_reg);
        q_v = div1024_trunc(sum_v_reg);

        if (q_y < 23'sd0)
            y8 = 8'd0;
        else if (q_y > 23'sd255)
            y8 = 8'd255;
        else
            y8 = q_y[7:0];

        if (q_u < -23'sd128)
            u8 = 8'h80;
        else if (q_u > 23'sd127)
            u8 = 8'h7f;
        else
            u8 = q_u[7:0];

        if (q_v < -23'sd128)
            v8 = 8'h80;
        else if (q_v > 23'sd127)
            v8 = 8'h7f;
        else
            v8 = q_v[7:0];

        if (act2_reg == yrcc_pkg::ACT_YUV_TO_RGB)
        begin
            red_next    = clamp_u8_rgb(sum_r_reg);
            green_next  = clamp_u8_rgb(sum_g_reg);
            blue_next   = clamp_u8_rgb(sum_b_reg);
            luma_next   = 8'd0;
            cb_next     = 8'd0;
            cr_next     = 8'd0;
            packed_next = 32'd0;
        end
        else
        begin
            red_next    = 8'd0;
            green_next  = 8'd0;
            blue_next   = 8'd0;
            luma_next   = y8;
            cb_next     = u8;
            cr_next     = v8;
            packed_next = {y8, v8, y8, u8};
        end
    end

    logic [7:0]  red_reg, green_reg, blue_reg, luma_reg, cb_reg, cr_reg;
    logic [31:0] packed_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            red_reg    <= red_next;
            green_reg  <= green_next;
            blue_reg   <= blue_next;
            luma_reg   <= luma_next;
            cb_reg     <= cb_next;
            cr_reg     <= cr_next;
            packed_reg <= packed_next;
        end
    end

    assign out_valid   = valid3_reg;
    assign red_out     = red_reg;
    assign green_out   = green_reg;
    assign blue_out    = blue_reg;
    assign luma_out    = luma_reg;
    assign cb_out      = $signed(cb_reg);
    assign cr_out      = $signed(cr_reg);
    assign packed_uyvy = packed_reg;

endmodule

>>> tb/sv/yuv_rgb_color_convert_unit_tb.sv
// self-checking testbench for yuv_rgb_color_convert_unit, ycbcr/rgb in both directions
// depends on yrcc_pkg and the rtl top level; predicts each pixel on its own, no other files

module yuv_rgb_color_convert_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_DEPTH   = 3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 120;
    localparam int PHASE_PIXELS = 154;

    typedef struct packed {
        logic       act;
        logic [7:0] y;
        logic [7:0] u;
        logic [7:0] v;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } pixel_t;

    typedef struct packed {
        logic [7:0]  r;
        logic [7:0]  g;
        logic [7:0]  b;
        logic [7:0]  y;
        logic [7:0]  u;
        logic [7:0]  v;
        logic [31:0] uyvy;
    } color_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_data = 1'b0;

    logic              in_valid = 1'b0;
    logic              in_ready;
    logic              action = 1'b0;
    logic [7:0]        luma_in = '0;
    logic signed [7:0] cb_in = '0;
    logic signed [7:0] cr_in = '0;
    logic [7:0]        red_in = '0;
    logic [7:0]        green_in = '0;
    logic [7:0]        blue_in = '0;

    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [7:0]        red_out;
    logic [7:0]        green_out;
    logic [7:0]        blue_out;
    logic [7:0]        luma_out;
    logic signed [7:0] cb_out;
    logic signed [7:0] cr_out;
    logic [31:0]       packed_uyvy;

    pixel_t pending_pixels[$];
    color_t expected_colors[$];

    logic std_model = yrcc_pkg::STD_BT601;
    logic in_taken = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_trigger = 0;
    int   hold_seen = 0;
    int   hold_left = 0;
    int   cycle_count = 0;
    int   error_count = 0;
    int   yuv_checked = 0;
    int   rgb_checked = 0;
    int   std_writes = 0;

    yuv_rgb_color_convert_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .luma_in     (luma_in),
        .cb_in       (cb_in),
        .cr_in       (cr_in),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .luma_out    (luma_out),
        .cb_out      (cb_out),
        .cr_out      (cr_out),
        .packed_uyvy (packed_uyvy)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_int(input int x, input int lo, input int hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic color_t convert_pixel(input pixel_t p, input logic sel);
        color_t c;
        int     y;
        int     u;
        int     v;
        int     rr;
        int     gg;
        int     bb;
        c = '0;
        if (p.act == yrcc_pkg::ACT_YUV_TO_RGB)
        begin
            y = p.y;
            u = $signed(p.u);
            v = $signed(p.v);
            if (sel == yrcc_pkg::STD_BT709)
            begin
                rr = y + ((1608 * v) >>> 10);
                gg = y + ((-191 * u) >>> 10) + ((-478 * v) >>> 10);
                bb = y + ((1900 * u) >>> 10);
            end
            else
            begin
                rr = y + ((1437 * v) >>> 10);
                gg = y + ((-352 * u) >>> 10) + ((-731 * v) >>> 10);
                bb = y + ((1812 * u) >>> 10);
            end
            c.r = 8'(clamp_int(rr, 0, 255));
            c.g = 8'(clamp_int(gg, 0, 255));
            c.b = 8'(clamp_int(bb, 0, 255));
        end
        else
        begin
            rr = p.r;
            gg = p.g;
            bb = p.b;
            // integer division truncates toward zero
            if (sel == yrcc_pkg::STD_BT709)
            begin
                y = (217 * rr + 732 * gg + 73 * bb) / 1024;
                u = (-117 * rr - 394 * gg + 512 * bb) / 1024;
                v = (512 * rr - 465 * gg - 46 * bb) / 1024;
            end
            else
            begin
                y = (306 * rr + 601 * gg + 116 * bb) / 1024;
                u = (-172 * rr - 337 * gg + 509 * bb) / 1024;
                v = (509 * rr - 427 * gg - 82 * bb) / 1024;
            end
            c.y = 8'(clamp_int(y, 0, 255));
            c.u = 8'(clamp_int(u, -128, 127));
            c.v = 8'(clamp_int(v, -128, 127));
            c.uyvy = {c.y, c.v, c.y, c.u};
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_byte();
        unique case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h80;
            3: return 8'h7f;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic queue_yuv(input logic [7:0] y, input logic [7:0] u, input logic [7:0] v);
        pixel_t p;
        p = {yrcc_pkg::ACT_YUV_TO_RGB, y, u, v, pick_byte(), pick_byte(), pick_byte()};
        pending_pixels.push_back(p);
    endtask

    task automatic queue_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        pixel_t p;
        p = {yrcc_pkg::ACT_RGB_TO_YUV, pick_byte(), pick_byte(), pick_byte(), r, g, b};
        pending_pixels.push_back(p);
    endtask

    task automatic queue_directed();
        queue_yuv(8'd0, 8'h80, 8'h80);
        queue_yuv(8'd255, 8'h7f, 8'h7f);
        queue_yuv(8'd0, 8'h7f, 8'h80);
        queue_yuv(8'd255, 8'h80, 8'h7f);
        queue_yuv(8'd128, 8'h00, 8'h00);
        // negative chroma products round toward minus infinity
        queue_yuv(8'd100, 8'hff, 8'h01);
        queue_rgb(8'd0, 8'd0, 8'd0);
        queue_rgb(8'd255, 8'd255, 8'd255);
        queue_rgb(8'd255, 8'd0, 8'd0);
        queue_rgb(8'd0, 8'd255, 8'd0);
        queue_rgb(8'd0, 8'd0, 8'd255);
        // small negative sums truncate toward zero
        queue_rgb(8'd3, 8'd0, 8'd0);
    endtask

    task automatic wait_drained();
        while (pending_pixels.size() != 0 || in_valid || expected_colors.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 2) @(posedge clk);
    endtask

    task automatic write_standard(input logic sel);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= sel;
        do
            @(posedge clk);
        while (!cfg_ready);
        std_model = sel;
        std_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // sender
    always @(negedge clk)
    begin
        pixel_t p;
        if (!in_valid || in_taken)
        begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                p = pending_pixels.pop_front();
                action   <= p.act;
                luma_in  <= p.y;
                cb_in    <= p.u;
                cr_in    <= p.v;
                red_in   <= p.r;
                green_in <= p.g;
                blue_in  <= p.b;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
        out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen <= hold_trigger;
            hold_left <= LONG_HOLD;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    // input transfers feed the predictor, output transfers are checked in order
    always @(posedge clk)
    begin
        pixel_t p;
        color_t want;
        in_taken <= in_valid && in_ready;
        if (out_valid && out_ready)
        begin
            if (expected_colors.size() == 0)
            begin
                $display("%0t: result transfer with nothing expected, uyvy %0h",
                         $time, packed_uyvy);
                error_count++;
            end
            else
            begin
                want = expected_colors.pop_front();
                check_field("red_out", want.r, red_out);
                check_field("green_out", want.g, green_out);
                check_field("blue_out", want.b, blue_out);
                check_field("luma_out", want.y, luma_out);
                check_field("cb_out", want.u, $unsigned(cb_out));
                check_field("cr_out", want.v, $unsigned(cr_out));
                check_field("packed_uyvy", want.uyvy, packed_uyvy);
            end
        end
        if (in_valid && in_ready)
        begin
            p = {action, luma_in, cb_in, cr_in, red_in, green_in, blue_in};
            expected_colors.push_back(convert_pixel(p, std_model));
            if (action == yrcc_pkg::ACT_YUV_TO_RGB)
                yuv_checked++;
            else
                rgb_checked++;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_colors.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int mode;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        write_standard(yrcc_pkg::STD_BT601);
        queue_directed();
        wait_drained();
        write_standard(yrcc_pkg::STD_BT709);
        queue_directed();
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            mode = ph / 2;
            write_standard((ph % 2 == 0) ? yrcc_pkg::STD_BT709 : yrcc_pkg::STD_BT601);
            unique case (mode)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            @(negedge clk);
            for (int i = 0; i < PHASE_PIXELS; i++)
            begin
                if ($urandom_range(1) == 0)
                    queue_yuv(pick_byte(), pick_byte(), pick_byte());
                else
                    queue_rgb(pick_byte(), pick_byte(), pick_byte());
            end
            // receiver backs off while the sender keeps offering
            if (mode == 0)
                hold_trigger++;
            wait_drained();
        end

        repeat (PIPE_DEPTH + 5) @(posedge clk);
        $display("checked %0d ycbcr->rgb and %0d rgb->ycbcr pixels", yuv_checked, rgb_checked);
        $display("%0d standard writes, both coefficient sets under four flow-control mixes",
                 std_writes);
        if (error_count == 0 && expected_colors.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
